/* design/hta_pkg.sv */
// Shared types and constants for the handle table allocator.
package hta_pkg;

    localparam int CMD_W        = 2;
    localparam int OBJ_W        = 32;
    localparam int HANDLE_IN_W  = 16;
    localparam int HANDLE_OUT_W = 11;
    localparam int STATUS_W     = 2;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_ALLOC,
        S_PUSH_SLOT,
        S_PUSH_COMMIT,
        S_DIV,
        S_LOOKUP,
        S_RESULT
    } state_t;

endpackage

/* design/hta_if.sv */
// Request and response channel interfaces of the handle table allocator.
interface hta_req_if;
    logic                             valid;
    logic                             ready;
    logic [hta_pkg::CMD_W-1:0]        cmd;
    logic [hta_pkg::OBJ_W-1:0]        obj_value;
    logic [hta_pkg::HANDLE_IN_W-1:0]  handle_in;

    modport source (output valid, output cmd, output obj_value, output handle_in,
                    input ready);
    modport sink   (input valid, input cmd, input obj_value, input handle_in,
                    output ready);
endinterface

interface hta_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [hta_pkg::HANDLE_OUT_W-1:0]  handle_out;
    logic [hta_pkg::OBJ_W-1:0]         obj_out;
    logic [hta_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output handle_out, output obj_out, output status,
                    input ready);
    modport sink   (input valid, input handle_out, input obj_out, input status,
                    output ready);
endinterface

/* design/hta_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/hta_div.sv */
// Divide of a 16-bit handle offset by a fixed divisor through reciprocal multiplication.
module hta_div #(
    parameter int DIVISOR = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [hta_pkg::HANDLE_IN_W-1:0] dividend,
    output logic                            done,
    output logic [hta_pkg::HANDLE_IN_W-1:0] quot,
    output logic [$clog2(DIVISOR)-1:0]      rem
);

    localparam int DW  = hta_pkg::HANDLE_IN_W;
    localparam int RW  = $clog2(DIVISOR);
    localparam int SH  = DW + RW;
    localparam int MW  = DW + 1;
    localparam int PRW = MW + DW;

    // ceil(2^SH / DIVISOR) gives the exact quotient for every DW-bit dividend
    localparam logic [63:0]   RECIP_WIDE = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) /
                                           64'(DIVISOR);
    localparam logic [MW-1:0] RECIP      = RECIP_WIDE[MW-1:0];
    localparam logic [DW-1:0] DIV_K      = DW'(DIVISOR);

    logic           ph1_reg, ph1_next;
    logic           ph2_reg, ph2_next;
    logic           done_reg, done_next;
    logic [DW-1:0]  dvd_reg, dvd_next;
    logic [DW-1:0]  quot_reg, quot_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [PRW-1:0] prod;
    logic [DW-1:0]  back;

    // Load, then quotient, then remainder, one step per cycle
    always_comb
    begin
        prod      = PRW'(dvd_reg) * PRW'(RECIP);
        back      = quot_reg * DIV_K;
        ph1_next  = start;
        ph2_next  = ph1_reg;
        done_next = ph2_reg;
        dvd_next  = start ? dividend : dvd_reg;
        quot_next = ph1_reg ? DW'(prod >> SH) : quot_reg;
        rem_next  = ph2_reg ? RW'(dvd_reg - back) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph1_reg  <= ph1_next;
            ph2_reg  <= ph2_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

/* design/handle_table_allocator.sv */
// Handle table allocator: two-level page/slot table with LIFO free lists.
// Push: page allocation, slot pick, commit, output register; a full table skips to the result.
// Remove, get: quotient, remainder, decode check, lookup/update, output register (no lookup if
// not found); unused commands go straight to the result. Throughput: one request at a time, taken
// again once the result is registered; a held result stalls the next request in its result step.
// Reset: asynchronous, active low; clears page directory and open list head; slot RAMs use high-water marks.
module handle_table_allocator #(
    parameter int PAGE_COUNT       = 16,
    parameter int ENTRIES_PER_PAGE = 64,
    parameter int PAGE_STRIDE      = 64,
    parameter int OBJ_WIDTH        = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hta_req_if.sink     req,
    hta_rsp_if.source   rsp
);

    localparam int PW  = $clog2(PAGE_COUNT + 1);
    localparam int PIW = $clog2(PAGE_COUNT);
    localparam int SW  = $clog2(ENTRIES_PER_PAGE + 1);
    localparam int SIW = $clog2(ENTRIES_PER_PAGE);
    localparam int NSL = PAGE_COUNT * ENTRIES_PER_PAGE;
    localparam int AW  = $clog2(NSL);
    localparam int RW  = $clog2(PAGE_STRIDE);
    localparam int VW  = (OBJ_WIDTH < hta_pkg::OBJ_W) ? OBJ_WIDTH : hta_pkg::OBJ_W;
    localparam int HW  = hta_pkg::HANDLE_IN_W;
    localparam int OW  = hta_pkg::HANDLE_OUT_W;
    localparam int DW  = hta_pkg::OBJ_W;
    localparam int STW = hta_pkg::STATUS_W;

    localparam logic [PW-1:0] PG_NULL = PW'(PAGE_COUNT);
    localparam logic [SW-1:0] SL_NULL = SW'(ENTRIES_PER_PAGE);

    function automatic logic [AW-1:0] slot_addr(input logic [PIW-1:0] p,
                                                input logic [SIW-1:0] s);
        return AW'(int'(p) * ENTRIES_PER_PAGE + int'(s));
    endfunction

    // Sequencer and request registers
    hta_pkg::state_t          state_reg, state_next;
    logic [hta_pkg::CMD_W-1:0] cmd_reg;
    logic [DW-1:0]            obj_reg;
    logic [HW-1:0]            handle_reg;
    logic [PW-1:0]            pg_reg, pg_next;
    logic [SW-1:0]            sl_reg, sl_next;
    logic                     fresh_reg, fresh_next;
    logic [OW-1:0]            res_handle_reg, res_handle_next;
    logic [DW-1:0]            res_obj_reg, res_obj_next;
    logic [STW-1:0]           res_status_reg, res_status_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [OW-1:0]            out_handle_reg;
    logic [DW-1:0]            out_obj_reg;
    logic [STW-1:0]           out_status_reg;

    // Page state
    logic [PAGE_COUNT-1:0]    page_in_use_reg;
    logic [PW-1:0]            dir_link_reg [PAGE_COUNT];
    logic [PW-1:0]            dir_head_reg;
    logic [SW-1:0]            next_free_reg [PAGE_COUNT];
    logic [SW-1:0]            usage_reg [PAGE_COUNT];
    logic [SW-1:0]            hwm_reg [PAGE_COUNT];
    logic [PW-1:0]            onext_reg [PAGE_COUNT];
    logic [PW-1:0]            oprev_reg [PAGE_COUNT];
    logic [PW-1:0]            ohead_reg;

    // Working signals
    logic                     accept;
    logic                     load_out;
    logic [PIW-1:0]           pidx;
    logic [SIW-1:0]           sidx;
    logic [PIW-1:0]           head_idx;
    logic [PIW-1:0]           dir_idx;
    logic [SW-1:0]            nf_head;
    logic [SW-1:0]            commit_link;
    logic [SW-1:0]            usage_dec;
    logic                     div_start;
    logic                     div_done;
    logic [HW-1:0]            div_q;
    logic [RW-1:0]            div_r;
    logic [PIW-1:0]           q_idx;
    logic                     found;
    logic                     present;

    // Table update controls
    logic                     do_alloc;
    logic                     do_push;
    logic                     do_remove;
    logic                     do_unlink;
    logic                     do_head_ins;
    logic                     do_release;

    // Slot memory ports
    logic                     link_we;
    logic [AW-1:0]            link_waddr;
    logic [SW:0]              link_wdata;
    logic [AW-1:0]            rd_addr;
    logic [SW:0]              link_rdata;
    logic                     val_we;
    logic [VW-1:0]            val_rdata;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == hta_pkg::S_IDLE);
    assign load_out  = (state_reg == hta_pkg::S_RESULT) && (!out_valid_reg || rsp.ready);
    assign pidx      = pg_reg[PIW-1:0];
    assign sidx      = sl_reg[SIW-1:0];
    assign head_idx  = ohead_reg[PIW-1:0];
    assign dir_idx   = dir_head_reg[PIW-1:0];
    assign nf_head   = next_free_reg[head_idx];
    assign q_idx     = div_q[PIW-1:0];
    assign present   = link_rdata[SW];
    assign usage_dec = usage_reg[pidx] - SW'(1);
    assign commit_link = fresh_reg ? (sl_reg + SW'(1)) : link_rdata[SW-1:0];
    assign div_start = accept && (req.cmd == hta_pkg::CMD_REMOVE ||
                                  req.cmd == hta_pkg::CMD_GET);

    // Handle decode check once the divide finishes
    assign found = (handle_reg != '0) && (div_q < HW'(PAGE_COUNT)) &&
                   page_in_use_reg[q_idx] && (int'(div_r) < int'(hwm_reg[q_idx]));

    hta_div #(
        .DIVISOR (PAGE_STRIDE)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.handle_in - HW'(1)),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // Per-slot present bit and free link
    hta_ram #(
        .WIDTH (SW + 1),
        .DEPTH (NSL)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    // Per-slot stored object
    hta_ram #(
        .WIDTH (VW),
        .DEPTH (NSL)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (link_waddr),
        .wdata (obj_reg[VW-1:0]),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hta_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == hta_pkg::CMD_PUSH)
                    begin
                        state_next = hta_pkg::S_PUSH_ALLOC;
                    end
                    else if (div_start)
                    begin
                        state_next = hta_pkg::S_DIV;
                    end
                    else
                    begin
                        state_next = hta_pkg::S_RESULT;
                    end
                end
            end
            hta_pkg::S_PUSH_ALLOC:
            begin
                if (ohead_reg >= PG_NULL && dir_head_reg >= PG_NULL)
                begin
                    state_next = hta_pkg::S_RESULT;
                end
                else
                begin
                    state_next = hta_pkg::S_PUSH_SLOT;
                end
            end
            hta_pkg::S_PUSH_SLOT:
            begin
                state_next = (nf_head >= SL_NULL) ? hta_pkg::S_RESULT
                                                  : hta_pkg::S_PUSH_COMMIT;
            end
            hta_pkg::S_PUSH_COMMIT:
            begin
                state_next = hta_pkg::S_RESULT;
            end
            hta_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = found ? hta_pkg::S_LOOKUP : hta_pkg::S_RESULT;
                end
            end
            hta_pkg::S_LOOKUP:
            begin
                state_next = hta_pkg::S_RESULT;
            end
            hta_pkg::S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = hta_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hta_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: table controls, memory ports, result
    always_comb
    begin
        pg_next         = pg_reg;
        sl_next         = sl_reg;
        fresh_next      = fresh_reg;
        res_handle_next = res_handle_reg;
        res_obj_next    = res_obj_reg;
        res_status_next = res_status_reg;
        do_alloc        = 1'b0;
        do_push         = 1'b0;
        do_remove       = 1'b0;
        do_unlink       = 1'b0;
        do_head_ins     = 1'b0;
        do_release      = 1'b0;
        link_we         = 1'b0;
        val_we          = 1'b0;
        link_waddr      = slot_addr(pidx, sidx);
        link_wdata      = {1'b1, SL_NULL};
        rd_addr         = slot_addr(q_idx, SIW'(div_r));
        case (state_reg)
            hta_pkg::S_IDLE:
            begin
                res_handle_next = '0;
                res_obj_next    = '0;
                res_status_next = hta_pkg::ST_NOT_FOUND;
            end
            hta_pkg::S_PUSH_ALLOC:
            begin
                if (ohead_reg >= PG_NULL)
                begin
                    if (dir_head_reg >= PG_NULL)
                    begin
                        res_status_next = hta_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_alloc = 1'b1;
                    end
                end
            end
            hta_pkg::S_PUSH_SLOT:
            begin
                rd_addr    = slot_addr(head_idx, nf_head[SIW-1:0]);
                pg_next    = ohead_reg;
                sl_next    = nf_head;
                fresh_next = nf_head >= hwm_reg[head_idx];
                if (nf_head >= SL_NULL)
                begin
                    res_status_next = hta_pkg::ST_FULL;
                end
            end
            hta_pkg::S_PUSH_COMMIT:
            begin
                do_push         = 1'b1;
                do_unlink       = commit_link >= SL_NULL;
                link_we         = 1'b1;
                val_we          = 1'b1;
                res_status_next = hta_pkg::ST_OK;
                res_handle_next = OW'(int'(pidx) * PAGE_STRIDE + int'(sidx) + 1);
            end
            hta_pkg::S_DIV:
            begin
                pg_next = PW'(q_idx);
                sl_next = SW'(div_r);
            end
            hta_pkg::S_LOOKUP:
            begin
                if (present)
                begin
                    res_status_next = hta_pkg::ST_OK;
                    if (cmd_reg == hta_pkg::CMD_GET)
                    begin
                        res_obj_next = DW'(val_rdata);
                    end
                    else
                    begin
                        do_remove   = 1'b1;
                        link_we     = 1'b1;
                        link_wdata  = {1'b0, next_free_reg[pidx]};
                        do_release  = (usage_dec == '0);
                        do_unlink   = (usage_dec == '0);
                        do_head_ins = (usage_dec != '0) && (usage_dec == SL_NULL - SW'(1));
                    end
                end
            end
            hta_pkg::S_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hta_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.cmd;
            obj_reg    <= req.obj_value;
            handle_reg <= req.handle_in;
        end
        pg_reg         <= pg_next;
        sl_reg         <= sl_next;
        fresh_reg      <= fresh_next;
        res_handle_reg <= res_handle_next;
        res_obj_reg    <= res_obj_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            out_handle_reg <= res_handle_reg;
            out_obj_reg    <= res_obj_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Page directory and open list head, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_in_use_reg <= '0;
            dir_head_reg    <= '0;
            ohead_reg       <= PG_NULL;
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                dir_link_reg[i] <= PW'(i + 1);
            end
        end
        else
        begin
            if (do_alloc)
            begin
                page_in_use_reg[dir_idx] <= 1'b1;
                dir_head_reg             <= dir_link_reg[dir_idx];
                ohead_reg                <= dir_head_reg;
            end
            if (do_unlink && oprev_reg[pidx] >= PG_NULL)
            begin
                ohead_reg <= onext_reg[pidx];
            end
            if (do_head_ins)
            begin
                ohead_reg <= pg_reg;
            end
            if (do_release)
            begin
                page_in_use_reg[pidx] <= 1'b0;
                dir_link_reg[pidx]    <= dir_head_reg;
                dir_head_reg          <= pg_reg;
            end
        end
    end

    // Per-page counters and open list links, defined once written
    always_ff @(posedge clk)
    begin
        if (do_alloc)
        begin
            next_free_reg[dir_idx] <= '0;
            usage_reg[dir_idx]     <= '0;
            hwm_reg[dir_idx]       <= '0;
            onext_reg[dir_idx]     <= PG_NULL;
            oprev_reg[dir_idx]     <= PG_NULL;
        end
        if (do_push)
        begin
            next_free_reg[pidx] <= commit_link;
            usage_reg[pidx]     <= usage_reg[pidx] + SW'(1);
            if (fresh_reg)
            begin
                hwm_reg[pidx] <= sl_reg + SW'(1);
            end
        end
        if (do_remove)
        begin
            next_free_reg[pidx] <= sl_reg;
            usage_reg[pidx]     <= usage_dec;
        end
        if (do_unlink)
        begin
            if (oprev_reg[pidx] < PG_NULL)
            begin
                onext_reg[oprev_reg[pidx][PIW-1:0]] <= onext_reg[pidx];
            end
            if (onext_reg[pidx] < PG_NULL)
            begin
                oprev_reg[onext_reg[pidx][PIW-1:0]] <= oprev_reg[pidx];
            end
        end
        if (do_head_ins)
        begin
            onext_reg[pidx] <= ohead_reg;
            oprev_reg[pidx] <= PG_NULL;
            if (ohead_reg < PG_NULL)
            begin
                oprev_reg[head_idx] <= pg_reg;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.obj_out    = out_obj_reg;
    assign rsp.status     = out_status_reg;

`ifndef NO_ASSERTIONS
    // Directory head is a page or the null code
    assert property (@(posedge clk) disable iff (!rst_n)
        dir_head_reg <= PG_NULL)
        else $error("directory free head out of range");

    // The page at the open list head is always in use
    assert property (@(posedge clk) disable iff (!rst_n)
        ohead_reg < PG_NULL |-> page_in_use_reg[head_idx])
        else $error("open list head page not in use");

    // A push only lands on a page with room left
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hta_pkg::S_PUSH_COMMIT |-> usage_reg[pidx] < SL_NULL)
        else $error("push into a full page");

    // A freshly allocated page becomes the open list head
    assert property (@(posedge clk) disable iff (!rst_n)
        do_alloc |=> ohead_reg == $past(dir_head_reg))
        else $error("allocated page not at open list head");
`endif

endmodule

/* sim/handle_table_allocator_test.sv */
// Testbench for the handle table allocator: queued stimulus, scoreboard model, random stalls.
module handle_table_allocator_test;

    localparam int NPG    = 16;
    localparam int NSLOT  = 64;
    localparam int STRIDE = 64;
    localparam int TOTAL  = NPG * NSLOT;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int FILL_LIVE    = 400;

    // Command code with no operation behind it
    localparam logic [hta_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [hta_pkg::CMD_W-1:0]       cmd;
        logic [hta_pkg::OBJ_W-1:0]       obj_value;
        logic [hta_pkg::HANDLE_IN_W-1:0] handle_in;
    } request_t;

    typedef struct packed {
        logic [hta_pkg::HANDLE_OUT_W-1:0] handle_out;
        logic [hta_pkg::OBJ_W-1:0]        obj_out;
        logic [hta_pkg::STATUS_W-1:0]     status;
    } result_t;

    logic clk;
    logic rst_n;

    hta_req_if req_ch ();
    hta_rsp_if rsp_ch ();

    handle_table_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Mirror of the table
    bit       pg_used [NPG];
    int       dir_link [NPG];
    int       dir_head;
    int       pg_free_slot [NPG];
    int       pg_count [NPG];
    int       open_nxt [NPG];
    int       open_prv [NPG];
    int       open_head;
    bit       slot_used [TOTAL];
    bit [31:0] slot_data [TOTAL];
    int       slot_link [TOTAL];

    request_t pending_reqs [$];
    result_t  expected_results [$];
    int       live_handles [$];
    int       fail_count;
    int       cycle_count = 0;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_active = 0;
    bit       pause_send = 0;
    event     hold_go;

    function automatic void open_remove(int p);
        if (open_prv[p] < NPG) open_nxt[open_prv[p]] = open_nxt[p];
        else open_head = open_nxt[p];
        if (open_nxt[p] < NPG) open_prv[open_nxt[p]] = open_prv[p];
    endfunction

    function automatic void open_insert(int p);
        open_nxt[p] = open_head;
        open_prv[p] = NPG;
        if (open_head < NPG) open_prv[open_head] = p;
        open_head = p;
    endfunction

    function automatic bit handle_lookup(int h, output int p, output int s);
        int v;
        v = h - 1;
        p = 0;
        s = 0;
        if (h == 0) return 0;
        p = v / STRIDE;
        s = v % STRIDE;
        if (p >= NPG) return 0;
        if (!pg_used[p] || s >= NSLOT) return 0;
        return slot_used[p * NSLOT + s];
    endfunction

    function automatic result_t table_predict(request_t r);
        result_t res;
        int p;
        int s;
        int b;
        int idx;
        res = '0;
        res.status = hta_pkg::ST_OK;
        if (r.cmd == hta_pkg::CMD_PUSH)
        begin
            if (open_head >= NPG)
            begin
                if (dir_head >= NPG)
                begin
                    res.status = hta_pkg::ST_FULL;
                    return res;
                end
                p = dir_head;
                dir_head = dir_link[p];
                pg_used[p] = 1;
                b = p * NSLOT;
                for (int i = 0; i < NSLOT; i++)
                begin
                    slot_link[b + i] = i + 1;
                    slot_used[b + i] = 0;
                end
                pg_free_slot[p] = 0;
                pg_count[p] = 0;
                open_insert(p);
            end
            p = open_head;
            s = pg_free_slot[p];
            if (s >= NSLOT)
            begin
                res.status = hta_pkg::ST_FULL;
                return res;
            end
            b = p * NSLOT;
            pg_free_slot[p] = slot_link[b + s];
            slot_used[b + s] = 1;
            slot_data[b + s] = r.obj_value;
            pg_count[p]++;
            if (pg_free_slot[p] >= NSLOT) open_remove(p);
            res.handle_out = hta_pkg::HANDLE_OUT_W'(p * STRIDE + s + 1);
            live_handles.push_back(p * STRIDE + s + 1);
        end
        else if (r.cmd == hta_pkg::CMD_REMOVE)
        begin
            if (!handle_lookup(r.handle_in, p, s))
            begin
                res.status = hta_pkg::ST_NOT_FOUND;
                return res;
            end
            b = p * NSLOT;
            slot_used[b + s] = 0;
            slot_link[b + s] = pg_free_slot[p];
            pg_free_slot[p] = s;
            pg_count[p]--;
            if (pg_count[p] == 0)
            begin
                open_remove(p);
                pg_used[p] = 0;
                dir_link[p] = dir_head;
                dir_head = p;
            end
            else if (pg_count[p] == NSLOT - 1)
            begin
                open_insert(p);
            end
            idx = -1;
            foreach (live_handles[k]) if (live_handles[k] == r.handle_in) idx = k;
            if (idx >= 0) live_handles.delete(idx);
        end
        else if (r.cmd == hta_pkg::CMD_GET)
        begin
            if (!handle_lookup(r.handle_in, p, s)) res.status = hta_pkg::ST_NOT_FOUND;
            else res.obj_out = slot_data[p * NSLOT + s];
        end
        else
        begin
            res.status = hta_pkg::ST_NOT_FOUND;
        end
        return res;
    endfunction

    // Stimulus helpers: handles mostly come from live ones at generation time
    function automatic int pick_live();
        if (live_handles.size() == 0) return $urandom_range(1, 1100);
        return live_handles[$urandom_range(0, live_handles.size() - 1)];
    endfunction

    task automatic add_req(logic [1:0] c, logic [31:0] o, logic [15:0] h);
        request_t r;
        r.cmd = c;
        r.obj_value = o;
        r.handle_in = h;
        pending_reqs.push_back(r);
    endtask

    task automatic add_random(int push_w, int rem_w);
        int pick;
        int h;
        pick = $urandom_range(0, 99);
        if (pick < push_w)
        begin
            add_req(hta_pkg::CMD_PUSH, $urandom, 16'($urandom));
        end
        else if (pick < push_w + rem_w)
        begin
            h = ($urandom_range(0, 9) == 0) ? int'($urandom) : pick_live();
            add_req(hta_pkg::CMD_REMOVE, $urandom, 16'(h));
        end
        else if (pick < 97)
        begin
            h = ($urandom_range(0, 9) == 0) ? int'($urandom) : pick_live();
            add_req(hta_pkg::CMD_GET, $urandom, 16'(h));
        end
        else
        begin
            add_req(CMD_UNUSED, $urandom, 16'($urandom));
        end
    endtask

    // The live handle list is kept by the predictor; generation only uses it as a hint.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Driver: the item on the bus stays at the head of the queue until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.cmd       <= '0;
            req_ch.obj_value <= '0;
            req_ch.handle_in <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(table_predict(pending_reqs.pop_front()));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && !pause_send &&
                    ($urandom_range(0, 99) >= send_idle_pct))
                begin
                    req_ch.valid     <= 1'b1;
                    req_ch.cmd       <= pending_reqs[0].cmd;
                    req_ch.obj_value <= pending_reqs[0].obj_value;
                    req_ch.handle_in <= pending_reqs[0].handle_in;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always
    begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result handle=%0d obj=%h status=%0d", $time,
                             rsp_ch.handle_out, rsp_ch.obj_out, rsp_ch.status);
                    fail_count++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (e.handle_out !== rsp_ch.handle_out)
                    begin
                        $display("%0t: handle_out expected %0d actual %0d", $time,
                                 e.handle_out, rsp_ch.handle_out);
                        fail_count++;
                    end
                    if (e.obj_out !== rsp_ch.obj_out)
                    begin
                        $display("%0t: obj_out expected %h actual %h", $time,
                                 e.obj_out, rsp_ch.obj_out);
                        fail_count++;
                    end
                    if (e.status !== rsp_ch.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.status, rsp_ch.status);
                        fail_count++;
                    end
                end
            end
            if (hold_active)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[handle_table_allocator] ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        fail_count = 0;
        send_idle_pct = 19;
        recv_idle_pct = 78;
        dir_head = 0;
        open_head = NPG;
        for (int i = 0; i < NPG; i++)
        begin
            pg_used[i] = 0;
            dir_link[i] = i + 1;
        end
        for (int i = 0; i < TOTAL; i++) slot_used[i] = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // Directed: unknown handles before anything exists, extremes, each command
        add_req(hta_pkg::CMD_GET, 32'h0, 16'h0);
        add_req(hta_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(CMD_UNUSED, 32'hFFFF_FFFF, 16'd1);
        add_req(hta_pkg::CMD_PUSH, 32'h0, 16'hFFFF);
        add_req(hta_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'h0);
        add_req(hta_pkg::CMD_PUSH, 32'hA5A5_5A5A, 16'h0);
        add_req(hta_pkg::CMD_GET, 32'h0, 16'd1);
        add_req(hta_pkg::CMD_GET, 32'h0, 16'd2);
        add_req(hta_pkg::CMD_GET, 32'h0, 16'd4);
        add_req(hta_pkg::CMD_GET, 32'h0, 16'd65);
        add_req(hta_pkg::CMD_GET, 32'h0, 16'd1025);
        add_req(hta_pkg::CMD_REMOVE, 32'h0, 16'd2);
        add_req(hta_pkg::CMD_REMOVE, 32'h0, 16'd2);
        add_req(hta_pkg::CMD_PUSH, 32'h1234_5678, 16'h0);
        add_req(hta_pkg::CMD_GET, 32'h0, 16'd2);
        add_req(hta_pkg::CMD_REMOVE, 32'h0, 16'd1);
        add_req(hta_pkg::CMD_REMOVE, 32'h0, 16'd2);
        add_req(hta_pkg::CMD_REMOVE, 32'h0, 16'd3);
        add_req(hta_pkg::CMD_GET, 32'h0, 16'd1);
        wait_drained();

        // Random with stalls, then long receiver hold-off while sender keeps offering
        for (n = 0; n < 150; n++) add_random(50, 25);
        -> hold_go;
        wait_drained();

        // Swap idling; grow across several pages, then drain pages back
        send_idle_pct = 78;
        recv_idle_pct = 19;
        for (n = 0; n < 150; n++) add_random(85, 5);
        wait_drained();
        while (live_handles.size() < FILL_LIVE)
        begin
            add_req(hta_pkg::CMD_PUSH, $urandom, 16'($urandom));
            wait_drained();
        end
        add_req(hta_pkg::CMD_PUSH, 32'hDEAD_BEEF, 16'h0);
        add_req(hta_pkg::CMD_REMOVE, 32'h0, 16'd300);
        add_req(hta_pkg::CMD_PUSH, 32'h0, 16'h0);
        add_req(hta_pkg::CMD_GET, 32'h0, 16'd300);
        for (n = 0; n < 150; n++) add_random(15, 70);
        wait_drained();

        // No idling; sender pauses midway until every result is back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (n = 0; n < 200; n++) add_random(40, 35);
        while (pending_reqs.size() > 100) @(posedge clk);
        pause_send <= 1'b1;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        pause_send <= 1'b0;
        wait_drained();

        repeat (60) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("[handle_table_allocator] OK");
        else
            $display("[handle_table_allocator] ERROR");
        $finish;
    end
endmodule
